// File: src/ief_pkg.sv
// types, codes and helpers shared by the infix expression evaluator
// no dependencies
package ief_pkg;

    localparam int MAX_NEST_DEF = 16;
    localparam int WORD_W = 32;

    // additive operator codes, bits 1:0 of the pending operator field
    localparam logic [1:0] ADD_NONE  = 2'd0;
    localparam logic [1:0] ADD_PLUS  = 2'd1;
    localparam logic [1:0] ADD_MINUS = 2'd2;

    // multiplicative operator codes, bits 3:2 of the pending operator field
    localparam logic [1:0] MUL_NONE  = 2'd0;
    localparam logic [1:0] MUL_TIMES = 2'd1;
    localparam logic [1:0] MUL_DIV   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_DEEP    = 2'd2;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [1:0] {
        PH_OPERAND,
        PH_SIGNED,
        PH_NUMBER,
        PH_AFTER
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAR,
        S_AOP,
        S_POP,
        S_APPLY,
        S_DIV,
        S_END,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        RET_AOP,
        RET_END,
        RET_FIN
    } ret_t;

    // one saved nesting level
    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] prod;
        logic [3:0]        ops;
    } frame_t;

    function automatic logic [WORD_W-1:0] close_term(input logic [1:0] aop,
                                                     input logic [WORD_W-1:0] sum,
                                                     input logic [WORD_W-1:0] prod);
        logic [WORD_W-1:0] r;
        if (aop == ADD_PLUS)
            r = sum + prod;
        else if (aop == ADD_MINUS)
            r = sum - prod;
        else
            r = prod;
        return r;
    endfunction

endpackage

// File: src/ief_div.sv
// radix-2 serial signed divider, truncates toward zero, 32 steps per quotient
// depends on ief_pkg
module ief_div
    import ief_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WORD_W);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] den_reg;
    logic              neg_reg;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] quo_next;

    assign shifted  = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
    assign trial    = {1'b0, shifted} - {1'b0, den_reg};
    assign quo_next = {quo_reg[WORD_W-2:0], ~trial[WORD_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            den_reg <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (run_reg)
        begin
            rem_reg <= trial[WORD_W] ? shifted : trial[WORD_W-1:0];
            quo_reg <= quo_next;
            if (cnt_reg == CNT_W'(WORD_W - 1))
                q_reg <= neg_reg ? (~quo_next + 1'b1) : quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: src/infix_expression_evaluator.sv
// infix integer expression evaluator, one character per item
// each accepted item passes S_CHAR and S_END; after an operand S_AOP lies between them, ending
// a number adds S_APPLY before S_AOP, ')' adds S_POP and S_APPLY after S_AOP, and a division waits in S_DIV
// the last character goes on to S_FIN to load the output register, and waits there while it is stalled
// reset clears parse state; the nesting stack memory is not cleared
// depends on ief_pkg and ief_div
module infix_expression_evaluator
    import ief_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic [1:0]         status
);

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    state_t            state_reg, state_next;
    ret_t              ret_reg, ret_next;
    logic [7:0]        c_reg;
    logic              last_reg;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [3:0]        ops_reg, ops_next;
    logic [WORD_W-1:0] num_reg, num_next;
    logic              neg_reg, neg_next;
    phase_t            phase_reg, phase_next;
    logic [1:0]        err_reg, err_next;
    logic [WORD_W-1:0] factor_reg, factor_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [1:0]        status_reg, status_next;

    frame_t            stack_mem [MAX_NEST];
    frame_t            rd_reg;
    logic              push_en;
    logic              pop_en;
    logic [DW-1:0]     depth_dec;

    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_q;

    logic              is_blank;
    logic              is_digit;
    logic [WORD_W-1:0] digit_val;
    logic [WORD_W-1:0] num_x10;
    logic [WORD_W-1:0] signed_num;
    logic [63:0]       mul_full;
    logic [WORD_W-1:0] closed_sum;

    assign is_blank   = (c_reg == CH_SPACE) || (c_reg == CH_TAB);
    assign is_digit   = (c_reg >= CH_ZERO) && (c_reg <= CH_NINE);
    assign digit_val  = {24'd0, c_reg - CH_ZERO};
    assign num_x10    = {num_reg[WORD_W-4:0], 3'b000} + {num_reg[WORD_W-2:0], 1'b0};
    assign signed_num = neg_reg ? (~num_reg + 1'b1) : num_reg;
    assign mul_full   = prod_reg * factor_reg;
    assign closed_sum = close_term(ops_reg[1:0], sum_reg, prod_reg);
    assign depth_dec  = depth_reg - 1'b1;

    ief_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (factor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        depth_next     = depth_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        ops_next       = ops_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        phase_next     = phase_reg;
        err_next       = err_reg;
        factor_next    = factor_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        push_en        = 1'b0;
        pop_en         = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHAR;
            end
            S_CHAR:
            begin
                state_next = S_END;
                if (err_reg == ST_OK)
                begin
                    unique case (phase_reg)
                        PH_OPERAND:
                        begin
                            if (is_blank)
                            begin
                            end
                            else if (c_reg == CH_LPAREN)
                            begin
                                if (depth_reg >= DW'(MAX_NEST))
                                    err_next = ST_DEEP;
                                else
                                begin
                                    push_en    = 1'b1;
                                    depth_next = depth_reg + 1'b1;
                                    sum_next   = '0;
                                    prod_next  = '0;
                                    ops_next   = '0;
                                end
                            end
                            else if (c_reg == CH_MINUS || c_reg == CH_PLUS)
                            begin
                                neg_next   = (c_reg == CH_MINUS);
                                phase_next = PH_SIGNED;
                            end
                            else if (is_digit)
                            begin
                                neg_next   = 1'b0;
                                num_next   = digit_val;
                                phase_next = PH_NUMBER;
                            end
                            else
                                err_next = ST_INVALID;
                        end
                        PH_SIGNED:
                        begin
                            if (is_digit)
                            begin
                                num_next   = digit_val;
                                phase_next = PH_NUMBER;
                            end
                            else if (!is_blank)
                                err_next = ST_INVALID;
                        end
                        PH_NUMBER:
                        begin
                            if (is_digit)
                                num_next = num_x10 + digit_val;
                            else
                            begin
                                factor_next = signed_num;
                                phase_next  = PH_AFTER;
                                ret_next    = RET_AOP;
                                state_next  = S_APPLY;
                            end
                        end
                        PH_AFTER:
                            state_next = S_AOP;
                    endcase
                end
            end
            S_AOP:
            begin
                state_next = S_END;
                if (err_reg == ST_OK)
                begin
                    if (is_blank)
                    begin
                    end
                    else if (c_reg == CH_STAR || c_reg == CH_SLASH)
                    begin
                        ops_next   = {(c_reg == CH_STAR) ? MUL_TIMES : MUL_DIV, ops_reg[1:0]};
                        phase_next = PH_OPERAND;
                    end
                    else if (c_reg == CH_PLUS || c_reg == CH_MINUS)
                    begin
                        sum_next   = closed_sum;
                        ops_next   = {MUL_NONE, (c_reg == CH_PLUS) ? ADD_PLUS : ADD_MINUS};
                        phase_next = PH_OPERAND;
                    end
                    else if (c_reg == CH_RPAREN)
                    begin
                        if (depth_reg == '0)
                            err_next = ST_INVALID;
                        else
                        begin
                            // inner value becomes the factor of the outer level
                            factor_next = closed_sum;
                            depth_next  = depth_dec;
                            pop_en      = 1'b1;
                            state_next  = S_POP;
                        end
                    end
                    else
                        err_next = ST_INVALID;
                end
            end
            S_POP:
            begin
                sum_next   = rd_reg.sum;
                prod_next  = rd_reg.prod;
                ops_next   = rd_reg.ops;
                phase_next = PH_AFTER;
                ret_next   = RET_END;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                unique case (ret_reg)
                    RET_AOP: state_next = S_AOP;
                    RET_END: state_next = S_END;
                    default: state_next = S_FIN;
                endcase
                if (ops_reg[3:2] == MUL_TIMES)
                begin
                    prod_next = mul_full[WORD_W-1:0];
                    ops_next  = {MUL_NONE, ops_reg[1:0]};
                end
                else if (ops_reg[3:2] == MUL_DIV)
                begin
                    if (factor_reg == '0)
                        err_next = ST_INVALID;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    prod_next = factor_reg;
                    ops_next  = {MUL_NONE, ops_reg[1:0]};
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    prod_next = div_q;
                    ops_next  = {MUL_NONE, ops_reg[1:0]};
                    unique case (ret_reg)
                        RET_AOP: state_next = S_AOP;
                        RET_END: state_next = S_END;
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_END:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (err_reg == ST_OK && phase_reg == PH_NUMBER)
                begin
                    factor_next = signed_num;
                    phase_next  = PH_AFTER;
                    ret_next    = RET_FIN;
                    state_next  = S_APPLY;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    if (err_reg != ST_OK)
                    begin
                        value_next  = '0;
                        status_next = err_reg;
                    end
                    else if (phase_reg != PH_AFTER || depth_reg != '0)
                    begin
                        value_next  = '0;
                        status_next = ST_INVALID;
                    end
                    else
                    begin
                        value_next  = closed_sum;
                        status_next = ST_OK;
                    end
                    out_valid_next = 1'b1;
                    depth_next     = '0;
                    sum_next       = '0;
                    prod_next      = '0;
                    ops_next       = '0;
                    num_next       = '0;
                    neg_next       = 1'b0;
                    phase_next     = PH_OPERAND;
                    err_next       = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= RET_END;
            depth_reg     <= '0;
            sum_reg       <= '0;
            prod_reg      <= '0;
            ops_reg       <= '0;
            num_reg       <= '0;
            neg_reg       <= 1'b0;
            phase_reg     <= PH_OPERAND;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            depth_reg     <= depth_next;
            sum_reg       <= sum_next;
            prod_reg      <= prod_next;
            ops_reg       <= ops_next;
            num_reg       <= num_next;
            neg_reg       <= neg_next;
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            c_reg    <= char_code;
            last_reg <= last_char;
        end
        factor_reg <= factor_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // nesting stack, one frame per level
    always_ff @(posedge clk)
    begin
        if (push_en)
            stack_mem[depth_reg[AW-1:0]] <= '{sum: sum_reg, prod: prod_reg, ops: ops_reg};
        if (pop_en)
            rd_reg <= stack_mem[depth_dec[AW-1:0]];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_NEST))
        else $error("nesting depth above limit");

    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> $past(depth_reg) == depth_reg + 1'b1)
        else $error("stack pop without depth decrement");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> factor_reg != '0)
        else $error("divider started with zero divisor");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg != 2'd3) && (status_reg == ST_OK || value_reg == '0))
        else $error("bad result status or nonzero value on error");

endmodule

// File: bench/infix_expression_evaluator_test.sv
// testbench for the infix expression evaluator: drives characters, checks value and status
// depends on ief_pkg and the evaluator rtl
`timescale 1ns / 1ps

module infix_expression_evaluator_test
    import ief_pkg::*;
();

    localparam int NEST = MAX_NEST_DEF;
    localparam int WATCHDOG = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         char_code;
    logic               last_char;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    infix_expression_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .last_char(last_char),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .status(status)
    );

    typedef struct {
        logic [31:0] val;
        logic [1:0]  st;
    } answer_t;

    // evaluator state mirror
    int unsigned depth;
    logic [31:0] stk_sum [NEST];
    logic [31:0] stk_prod [NEST];
    logic [3:0]  stk_ops [NEST];
    logic [31:0] acc_sum, acc_prod, num_val;
    logic [3:0]  ops;
    logic        num_neg;
    phase_t      phase;
    logic [1:0]  err;

    answer_t     answers [$];
    int          errors = 0;
    int          exprs_done = 0;
    int          chars_sent = 0;
    int          idle_cycles = 0;
    bit          feeding_done = 0;

    function automatic bit blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void raise(logic [1:0] code);
        if (err == ST_OK)
            err = code;
    endfunction

    function automatic void clear_state();
        depth = 0;
        acc_sum = '0;
        acc_prod = '0;
        ops = '0;
        num_val = '0;
        num_neg = 0;
        phase = PH_OPERAND;
        err = ST_OK;
    endfunction

    function automatic void fold_factor(logic [31:0] f);
        logic [1:0] m;
        m = ops[3:2];
        if (m == MUL_TIMES)
            acc_prod = acc_prod * f;
        else if (m == MUL_DIV) begin
            if (f == 0) begin
                raise(ST_INVALID);
                return;
            end
            // most negative / -1 wraps back to itself
            if (acc_prod == 32'h8000_0000 && f == 32'hFFFF_FFFF)
                acc_prod = 32'h8000_0000;
            else
                acc_prod = $signed(acc_prod) / $signed(f);
        end else
            acc_prod = f;
        ops[3:2] = MUL_NONE;
    endfunction

    function automatic void fold_term();
        if (ops[1:0] == ADD_PLUS)
            acc_sum = acc_sum + acc_prod;
        else if (ops[1:0] == ADD_MINUS)
            acc_sum = acc_sum - acc_prod;
        else
            acc_sum = acc_prod;
        ops = '0;
    endfunction

    function automatic void finish_number();
        phase = PH_AFTER;
        fold_factor(num_neg ? -num_val : num_val);
    endfunction

    function automatic void after_operand(logic [7:0] c);
        logic [31:0] v;
        if (blank(c))
            return;
        if (c == CH_STAR || c == CH_SLASH) begin
            ops[3:2] = (c == CH_STAR) ? MUL_TIMES : MUL_DIV;
            phase = PH_OPERAND;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            fold_term();
            ops[1:0] = (c == CH_PLUS) ? ADD_PLUS : ADD_MINUS;
            phase = PH_OPERAND;
        end else if (c == CH_RPAREN) begin
            if (depth == 0) begin
                raise(ST_INVALID);
                return;
            end
            fold_term();
            v = acc_sum;
            depth--;
            acc_sum = stk_sum[depth];
            acc_prod = stk_prod[depth];
            ops = stk_ops[depth];
            phase = PH_AFTER;
            fold_factor(v);
        end else
            raise(ST_INVALID);
    endfunction

    function automatic void want_operand(logic [7:0] c);
        if (blank(c))
            return;
        if (c == CH_LPAREN) begin
            if (depth >= NEST) begin
                raise(ST_DEEP);
                return;
            end
            stk_sum[depth] = acc_sum;
            stk_prod[depth] = acc_prod;
            stk_ops[depth] = ops;
            depth++;
            acc_sum = '0;
            acc_prod = '0;
            ops = '0;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            num_neg = (c == CH_MINUS);
            phase = PH_SIGNED;
        end else if (digit(c)) begin
            num_neg = 0;
            num_val = c - CH_ZERO;
            phase = PH_NUMBER;
        end else
            raise(ST_INVALID);
    endfunction

    // advance the mirror by one character; pushes an answer on the last one
    function automatic void eval_char(logic [7:0] c, logic last);
        answer_t a;
        if (err == ST_OK) begin
            case (phase)
                PH_OPERAND: want_operand(c);
                PH_SIGNED:
                    if (digit(c)) begin
                        num_val = c - CH_ZERO;
                        phase = PH_NUMBER;
                    end else if (!blank(c))
                        raise(ST_INVALID);
                PH_NUMBER:
                    if (digit(c))
                        num_val = num_val * 10 + (c - CH_ZERO);
                    else begin
                        finish_number();
                        if (err == ST_OK)
                            after_operand(c);
                    end
                default: after_operand(c);
            endcase
        end
        if (!last)
            return;
        if (err == ST_OK && phase == PH_NUMBER)
            finish_number();
        if (err == ST_OK) begin
            if (phase != PH_AFTER || depth != 0)
                raise(ST_INVALID);
            else
                fold_term();
        end
        a.val = (err == ST_OK) ? acc_sum : '0;
        a.st = err;
        answers.push_back(a);
        clear_state();
    endfunction

    // directed expressions; fixed answers where obvious, otherwise predictor
    typedef struct {
        string      text;
        bit         fixed;
        logic [31:0] val;
        logic [1:0]  st;
    } row_t;

    row_t directed [] = '{
        '{"7", 1, 32'd7, ST_OK},
        '{"1+2*3", 1, 32'd7, ST_OK},
        '{"(1+2)*3", 1, 32'd9, ST_OK},
        '{" -\t 12 - -3 ", 1, -32'sd9, ST_OK},
        '{"7/-2", 1, -32'sd3, ST_OK},
        '{"8/0", 1, 32'd0, ST_INVALID},
        '{"2147483647+1", 1, 32'h8000_0000, ST_OK},
        '{"-2147483648/-1", 1, 32'h8000_0000, ST_OK},
        '{"99999999999*3", 0, 0, 0},
        '{"65536*65536", 1, 32'd0, ST_OK},
        '{"1)", 1, 32'd0, ST_INVALID},
        '{"(1", 1, 32'd0, ST_INVALID},
        '{"1+", 1, 32'd0, ST_INVALID},
        '{"-", 1, 32'd0, ST_INVALID},
        '{" ", 1, 32'd0, ST_INVALID},
        '{"-(2)", 1, 32'd0, ST_INVALID},
        '{"1a2", 1, 32'd0, ST_INVALID},
        '{"((((((((((((((((1))))))))))))))))", 1, 32'd1, ST_OK},
        '{"(((((((((((((((((1)))))))))))))))))", 1, 32'd0, ST_DEEP},
        '{"1/0+(((", 1, 32'd0, ST_INVALID},
        '{"100/7*7-(3-10)/(2)", 0, 0, 0},
        '{"+5*-4", 1, -32'sd20, ST_OK}
    };

    // random well-formed expression, depth-bounded
    function automatic string rand_expr(int lvl);
        string s;
        string opc;
        int terms;
        int k;
        opc = "+-*/";
        terms = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < terms; i++) begin
            if (i > 0) begin
                k = $urandom_range(0, 3);
                s = {s, opc.substr(k, k)};
            end
            if ($urandom_range(0, 4) == 0)
                s = {s, " "};
            if (lvl < NEST + 1 && $urandom_range(0, 3) == 0)
                s = {s, "(", rand_expr(lvl + 1), ")"};
            else begin
                if ($urandom_range(0, 3) == 0)
                    s = {s, ($urandom_range(0, 1) ? "-" : "+")};
                case ($urandom_range(0, 3))
                    0: s = {s, $sformatf("%0d", $urandom_range(0, 9))};
                    1: s = {s, $sformatf("%0d", $urandom_range(0, 999))};
                    2: s = {s, $sformatf("%0d", $urandom())};
                    default: s = {s, $sformatf("%0d%0d", $urandom(), $urandom_range(0, 99))};
                endcase
            end
        end
        return s;
    endfunction

    function automatic string rand_noise();
        string s;
        string one;
        int n;
        n = $urandom_range(1, 8);
        s = "";
        one = " ";
        for (int i = 0; i < n; i++) begin
            one[0] = 8'($urandom_range(1, 255));
            s = {s, one};
        end
        return s;
    endfunction

    // random gap: mostly none or short, sometimes long
    function automatic int gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
    end

    // character sender
    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            int g;
            g = gap();
            if (g > 0) begin
                in_valid <= 0;
                repeat (g) @(posedge clk);
            end
            in_valid <= 1;
            char_code <= s[i];
            last_char <= (i == s.len() - 1);
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            chars_sent++;
            eval_char(s[i], i == s.len() - 1);
        end
    endtask

    initial
    begin
        row_t rw;
        string s;
        in_valid = 0;
        char_code = 8'h20;
        last_char = 0;
        clear_state();
        @(posedge rst_n);
        @(posedge clk);
        foreach (directed[k]) begin
            rw = directed[k];
            send_text(rw.text);
            if (rw.fixed && (answers[$].val !== rw.val || answers[$].st !== rw.st)) begin
                $error("table row %0d predictor disagrees: %h/%0d vs %h/%0d", k,
                       answers[$].val, answers[$].st, rw.val, rw.st);
                errors++;
            end
        end
        while (chars_sent < 1600) begin
            case ($urandom_range(0, 9))
                0: s = rand_noise();
                1: begin
                    s = rand_expr(0);
                    s = s.substr(0, $urandom_range(0, s.len() - 1));
                end
                2: s = {rand_expr(0), rand_noise()};
                default: s = rand_expr(0);
            endcase
            send_text(s);
        end
        in_valid <= 0;
        feeding_done = 1;
    end

    // result side with random stall
    initial
    begin
        answer_t fx;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (answers.size() == 0) begin
                    $error("unexpected result value=%h status=%0d", value, status);
                    errors++;
                end else begin
                    fx = answers.pop_front();
                    if (value !== fx.val) begin
                        $error("value expected %h actual %h", fx.val, value);
                        errors++;
                    end
                    if (status !== fx.st) begin
                        $error("status expected %0d actual %0d", fx.st, status);
                        errors++;
                    end
                    exprs_done++;
                end
            end
            out_ready <= (gap() == 0);
        end
    end

    // watchdog and end of run
    initial
    begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (feeding_done && answers.size() == 0) begin
                repeat (50) @(posedge clk);
                $display("sent %0d characters, checked %0d expression results",
                         chars_sent, exprs_done);
                if (errors == 0 && answers.size() == 0)
                    $display("TEST PASSED");
                else
                    $display("TEST FAILED");
                $finish;
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog: no progress, %0d results outstanding", answers.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
